// ----- src/a2p_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2p_pkg
// Shared types and Q30 constants for the degree-11 atan2 pipeline.
// ----------------------------------------------------------------------------
package a2p_pkg;

  // Horner accumulator width, signed Q30
  localparam int ACC_W  = 32;
  // Folded angle width, signed Q30, holds +/- pi
  localparam int FOLD_W = 34;
  localparam int WORK_FRAC = 30;

  localparam logic signed [ACC_W-1:0] K_C11 = 32'sd14474544;
  localparam logic signed [ACC_W-1:0] K_C9  = 32'sd61715796;
  localparam logic signed [ACC_W-1:0] K_C7  = 32'sd130179461;
  localparam logic signed [ACC_W-1:0] K_C5  = 32'sd210062475;
  localparam logic signed [ACC_W-1:0] K_C3  = 32'sd357550226;
  localparam logic signed [ACC_W-1:0] K_C1  = 32'sd1073737132;
  localparam logic signed [FOLD_W-1:0] K_HALF_PI = 34'sd1686629713;
  localparam logic signed [FOLD_W-1:0] K_PI      = 34'sd3373259426;

  // Octant flags that ride along with each beat
  typedef struct packed {
    logic swap;   // |y| > |x|
    logic xneg;
    logic yneg;
    logic zero;   // both components zero
  } flags_t;

endpackage

// ----- src/a2p_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2p_div_cell
// One restoring-division step: produces one quotient bit of min/max.
// ----------------------------------------------------------------------------
module a2p_div_cell import a2p_pkg::*; #(
  parameter int IW    = 16,
  parameter int RB    = 16,
  parameter bit FIRST = 1'b0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [IW:0]   in_rem,
  input  logic [IW-1:0] in_mx,
  input  logic [RB-1:0] in_q,
  input  flags_t        in_flags,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [IW:0]   out_rem,
  output logic [IW-1:0] out_mx,
  output logic [RB-1:0] out_q,
  output flags_t        out_flags
);

  logic [IW:0] shifted;
  logic [IW:0] diff;
  logic        take;

  assign in_ready = !out_valid || out_ready;

  // Shift the partial remainder and trial-subtract the divisor
  always_comb begin
    shifted = FIRST ? in_rem : {in_rem[IW-1:0], 1'b0};
    take    = shifted >= {1'b0, in_mx};
    diff    = shifted - {1'b0, in_mx};
  end

  // Hold control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rem   <= take ? diff : shifted;
      out_mx    <= in_mx;
      out_q     <= {in_q[RB-2:0], take};
      out_flags <= in_flags;
    end
  end

endmodule

// ----- src/a2p_mac_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2p_mac_cell
// One Horner step: acc * operand, rounded back to Q30, plus a constant.
// ----------------------------------------------------------------------------
module a2p_mac_cell import a2p_pkg::*; #(
  parameter int RB     = 16,
  parameter bit USE_R  = 1'b0,
  parameter bit LOAD_S = 1'b0,
  parameter logic signed [ACC_W-1:0] ADD = '0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [ACC_W-1:0] in_acc,
  input  logic [RB-1:0]           in_r,
  input  logic [RB-1:0]           in_s,
  input  flags_t                  in_flags,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ACC_W-1:0] out_acc,
  output logic [RB-1:0]           out_r,
  output logic [RB-1:0]           out_s,
  output flags_t                  out_flags
);

  localparam int PW = ACC_W + RB + 1;
  localparam int SH = RB - 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (SH - 1);

  logic signed [PW-1:0]    prod;
  logic [PW-1:0]           mag;
  logic [PW-1:0]           qm;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] res;
  logic [RB-1:0]           opnd;

  assign in_ready = !out_valid || out_ready;

  // Multiply, round ties away from zero, add the coefficient
  always_comb begin
    opnd = USE_R ? in_r : in_s;
    prod = PW'(in_acc) * $signed({1'b0, opnd});
    mag  = prod[PW-1] ? PW'(-prod) : PW'(prod);
    qm   = (mag + HALF) >> SH;
    rnd  = prod[PW-1] ? -$signed(qm[ACC_W-1:0]) : $signed(qm[ACC_W-1:0]);
    res  = rnd + ADD;
  end

  // Hold control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Advance payload; the squaring cell loads s and seeds the accumulator
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_r     <= in_r;
      out_flags <= in_flags;
      if (LOAD_S) begin
        out_s   <= res[RB-1:0];
        out_acc <= -K_C11;
      end else begin
        out_s   <= in_s;
        out_acc <= res;
      end
    end
  end

endmodule

// ----- src/atan2_odd_poly_degree11.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_odd_poly_degree11
// Four-quadrant arctangent by min/max ratio and odd degree-11 polynomial.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one (y, x) sample pair per beat; m_tdata returns the
//   angle in signed radians with ANGLE_FRAC_BITS fraction bits, saturated
//   to +/- pi. Both sides are valid/ready streams.
//   Throughput is one pair per cycle while m_tready does not stall the
//   pipeline. The path runs through one cell per quotient bit of the ratio
//   divider, seven multiply cells (square plus Horner plus final r),
//   one octant-fold stage and the round/saturate output register.
//   Every stage holds its own valid bit, so a stall at m_tready fills
//   empty stages first and s_tready drops only when the whole row is full.
//   Reset clears all valid bits; the payload registers are not reset.
//   x = y = 0 yields 0.
// ----------------------------------------------------------------------------
module atan2_odd_poly_degree11 import a2p_pkg::*; #(
  parameter int INPUT_WIDTH     = 16,
  parameter int RATIO_FRAC_BITS = 15,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // y_value (low INPUT_WIDTH bits), x_value (next INPUT_WIDTH bits), zero pad
  input  logic [((2*INPUT_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // angle (low ANGLE_FRAC_BITS+3 bits), zero pad
  output logic [((ANGLE_FRAC_BITS+3+7)/8)*8-1:0] m_tdata
);

  localparam int IW = INPUT_WIDTH;
  localparam int RB = RATIO_FRAC_BITS + 1;
  localparam int AW = ANGLE_FRAC_BITS + 3;
  localparam int OW = ((AW + 7) / 8) * 8;
  localparam int SH = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam logic [FOLD_W-1:0] HALF = FOLD_W'(1) << (SH - 1);
  localparam logic signed [FOLD_W-1:0] LIM =
    FOLD_W'((64'(K_PI) + (64'd1 << (SH - 1))) >> SH);
  localparam int NMAC = 7;

  // Coefficient added after each multiply cell
  function automatic logic signed [ACC_W-1:0] mac_add(int idx);
    logic signed [ACC_W-1:0] k;
    unique case (idx)
      1:       k = K_C9;
      2:       k = -K_C7;
      3:       k = K_C5;
      4:       k = -K_C3;
      5:       k = K_C1;
      default: k = '0;
    endcase
    return k;
  endfunction

  // Input unpack and magnitude compare
  logic signed [IW-1:0] y_value, x_value;
  logic [IW-1:0] ay, ax, mx, mn;
  flags_t in_flags;

  always_comb begin
    y_value = s_tdata[IW-1:0];
    x_value = s_tdata[2*IW-1:IW];
    ay = y_value[IW-1] ? IW'(-y_value) : IW'(y_value);
    ax = x_value[IW-1] ? IW'(-x_value) : IW'(x_value);
    in_flags.swap = ay > ax;
    in_flags.xneg = x_value[IW-1];
    in_flags.yneg = y_value[IW-1];
    in_flags.zero = (ay == '0) && (ax == '0);
    mx = in_flags.swap ? ay : ax;
    mn = in_flags.swap ? ax : ay;
  end

  // Divider row
  logic          dv_valid [RB+1];
  logic          dv_ready [RB+1];
  logic [IW:0]   dv_rem   [RB+1];
  logic [IW-1:0] dv_mx    [RB+1];
  logic [RB-1:0] dv_q     [RB+1];
  flags_t        dv_flags [RB+1];

  assign dv_valid[0] = s_tvalid;
  assign s_tready    = dv_ready[0];
  assign dv_rem[0]   = {1'b0, mn};
  assign dv_mx[0]    = mx;
  assign dv_q[0]     = '0;
  assign dv_flags[0] = in_flags;

  for (genvar i = 0; i < RB; i++) begin : g_div
    a2p_div_cell #(.IW(IW), .RB(RB), .FIRST(i == 0)) u_cell (
      .clk, .rst,
      .in_valid (dv_valid[i]),   .in_ready  (dv_ready[i]),
      .in_rem   (dv_rem[i]),     .in_mx     (dv_mx[i]),
      .in_q     (dv_q[i]),       .in_flags  (dv_flags[i]),
      .out_valid(dv_valid[i+1]), .out_ready (dv_ready[i+1]),
      .out_rem  (dv_rem[i+1]),   .out_mx    (dv_mx[i+1]),
      .out_q    (dv_q[i+1]),     .out_flags (dv_flags[i+1])
    );
  end

  // Multiply row: square, five Horner steps, final multiply by r
  logic                    mc_valid [NMAC+1];
  logic                    mc_ready [NMAC+1];
  logic signed [ACC_W-1:0] mc_acc   [NMAC+1];
  logic [RB-1:0]           mc_r     [NMAC+1];
  logic [RB-1:0]           mc_s     [NMAC+1];
  flags_t                  mc_flags [NMAC+1];

  assign mc_valid[0]  = dv_valid[RB];
  assign dv_ready[RB] = mc_ready[0];
  assign mc_acc[0]    = ACC_W'(dv_q[RB]);
  assign mc_r[0]      = dv_q[RB];
  assign mc_s[0]      = '0;
  assign mc_flags[0]  = dv_flags[RB];

  for (genvar i = 0; i < NMAC; i++) begin : g_mac
    a2p_mac_cell #(
      .RB(RB), .USE_R(i == 0 || i == NMAC - 1), .LOAD_S(i == 0), .ADD(mac_add(i))
    ) u_cell (
      .clk, .rst,
      .in_valid (mc_valid[i]),   .in_ready  (mc_ready[i]),
      .in_acc   (mc_acc[i]),     .in_r      (mc_r[i]),
      .in_s     (mc_s[i]),       .in_flags  (mc_flags[i]),
      .out_valid(mc_valid[i+1]), .out_ready (mc_ready[i+1]),
      .out_acc  (mc_acc[i+1]),   .out_r     (mc_r[i+1]),
      .out_s    (mc_s[i+1]),     .out_flags (mc_flags[i+1])
    );
  end

  // Octant fold stage
  logic                     fold_valid;
  logic                     fold_ready;
  logic signed [FOLD_W-1:0] fold;
  logic signed [FOLD_W-1:0] fold_next;
  logic                     fold_zero;

  always_comb begin
    fold_next = FOLD_W'(mc_acc[NMAC]);
    if (mc_flags[NMAC].swap) fold_next = K_HALF_PI - fold_next;
    if (mc_flags[NMAC].xneg) fold_next = K_PI - fold_next;
    if (mc_flags[NMAC].yneg) fold_next = -fold_next;
  end

  assign mc_ready[NMAC] = !fold_valid || fold_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_valid <= 1'b0;
    end else if (mc_ready[NMAC]) begin
      fold_valid <= mc_valid[NMAC];
    end
  end

  always_ff @(posedge clk) begin
    if (mc_ready[NMAC] && mc_valid[NMAC]) begin
      fold      <= fold_next;
      fold_zero <= mc_flags[NMAC].zero;
    end
  end

  // Round to the output scale, saturate to +/- pi, and force 0 for x = y = 0
  logic [FOLD_W-1:0]        fmag;
  logic [FOLD_W-1:0]        fq;
  logic signed [FOLD_W-1:0] frnd;
  logic signed [FOLD_W-1:0] fsat;
  logic [AW-1:0]            angle;

  always_comb begin
    fmag = fold[FOLD_W-1] ? FOLD_W'(-fold) : FOLD_W'(fold);
    fq   = (fmag + HALF) >> SH;
    frnd = fold[FOLD_W-1] ? -$signed(fq) : $signed(fq);
    if (fold_zero)       fsat = '0;
    else if (frnd > LIM) fsat = LIM;
    else if (frnd < -LIM) fsat = -LIM;
    else                 fsat = frnd;
  end

  assign fold_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fold_ready) begin
      m_tvalid <= fold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fold_ready && fold_valid) begin
      angle <= fsat[AW-1:0];
    end
  end

  assign m_tdata = OW'(angle);

endmodule
